@@ rtl/core/fad_pkg.sv @@
// ----------------------------------------------------------------------------
// fad_pkg
// Shared types and codes for the fixed array deque: command and status codes,
// sequencer states and the request and response payload structs.
// ----------------------------------------------------------------------------
package fad_pkg;

   // Command codes carried in the request
   typedef enum logic [2:0] {
      CMD_REAR_INS  = 3'd0,
      CMD_REAR_DEL  = 3'd1,
      CMD_FRONT_INS = 3'd2,
      CMD_FRONT_DEL = 3'd3,
      CMD_DISPLAY   = 3'd4
   } cmd_type;

   // Status codes returned in every response
   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_REAR_FULL  = 2'd1,
      STS_FRONT_FULL = 2'd2,
      STS_EMPTY      = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SHOW = 1'b1
   } state_type;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 4;

   typedef struct packed {
      logic [2:0]                   command;
      logic signed [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [ValueWidth-1:0] element;
      logic [CountWidth-1:0]        count;
      logic                         last;
   } rsp_type;

endpackage

@@ rtl/core/fad_ram.sv @@
// ----------------------------------------------------------------------------
// fad_ram
// Slot store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fad_ram import fad_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic signed [ValueWidth-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic signed [ValueWidth-1:0] rd_data
);

   logic signed [ValueWidth-1:0] mem [DEPTH];
   logic signed [ValueWidth-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fad_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// fad_rsp_reg
// Response output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module fad_rsp_reg import fad_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // can load when empty or when the held result transfers this cycle
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = free ? push : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ rtl/core/fixed_array_deque_core.sv @@
// ----------------------------------------------------------------------------
// fixed_array_deque_core
// Non-circular double-ended queue held in a DEPTH-slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a command and a value; rsp channel returns status,
//   element, element count after the operation and a last marker.
//   Inserts, deletes and unknown commands give one response; it is loaded
//   into the output register at the accepting edge and is visible the next
//   cycle. One such command is taken per cycle while the output register
//   can load.
//   Display of a non-empty store streams the held values from front to rear,
//   one per cycle while the output register can load, through the slot
//   memory's registered read port; the request side stalls until the last
//   value is pushed. The final response of each request has last set.
//   Reset empties the queue (front and rear at slot 0); slot contents are
//   not cleared and no clearing pass is needed.
//   When the receiver stalls, the output register holds its result and the
//   request side is stalled until it can load again; a display pauses in
//   place and resumes without loss.
// ----------------------------------------------------------------------------
module fixed_array_deque_core import fad_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

   state_type state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] rear_ff, rear_in;
   logic          empty_ff, empty_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_more_ff, rd_more_in;
   logic          rd_last_ff, rd_last_in;
   logic          rd_vld_ff, rd_vld_in;

   logic          accept;
   logic          out_free;
   logic          push_show;
   logic          push;
   rsp_type       push_data;
   status_type    status_sel;
   logic signed [ValueWidth-1:0] elem_sel;
   logic          last_sel;
   logic [AW:0]   cnt_after;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic signed [ValueWidth-1:0] rd_data;

   assign accept    = req_valid && !req_stall;
   assign push_show = (state_ff == ST_SHOW) && rd_vld_ff && out_free;

   // slot store
   fad_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   fad_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.command == CMD_DISPLAY && !empty_ff) begin
               state_in = ST_SHOW;
            end
         end
         ST_SHOW: begin
            if (push_show && rd_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs, pointer updates and display read sequencing
   always_comb begin
      req_stall  = 1'b1;
      front_in   = front_ff;
      rear_in    = rear_ff;
      empty_in   = empty_ff;
      rd_addr_in = rd_addr_ff;
      rd_more_in = rd_more_ff;
      rd_last_in = rd_last_ff;
      rd_vld_in  = rd_vld_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      rd_en      = 1'b0;
      rd_addr    = rd_addr_ff;
      push       = 1'b0;
      status_sel = STS_OK;
      elem_sel   = '0;
      last_sel   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (accept) begin
               push = 1'b1;
               case (req_data.command)
                  CMD_REAR_INS: begin
                     if (empty_ff) begin
                        wr_en    = 1'b1;
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b0;
                     end else if (rear_ff == LastIdx) begin
                        status_sel = STS_REAR_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = rear_ff + 1'b1;
                        rear_in = rear_ff + 1'b1;
                     end
                  end
                  CMD_REAR_DEL: begin
                     if (empty_ff) begin
                        status_sel = STS_EMPTY;
                     end else if (front_ff == rear_ff) begin
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b1;
                     end else begin
                        rear_in = rear_ff - 1'b1;
                     end
                  end
                  CMD_FRONT_INS: begin
                     if (empty_ff) begin
                        wr_en    = 1'b1;
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b0;
                     end else if (front_ff == '0) begin
                        status_sel = STS_FRONT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_ff - 1'b1;
                        front_in = front_ff - 1'b1;
                     end
                  end
                  CMD_FRONT_DEL: begin
                     if (empty_ff) begin
                        status_sel = STS_EMPTY;
                     end else if (front_ff == rear_ff) begin
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b1;
                     end else begin
                        front_in = front_ff + 1'b1;
                     end
                  end
                  CMD_DISPLAY: begin
                     if (empty_ff) begin
                        status_sel = STS_EMPTY;
                     end else begin
                        // results come from the streaming state
                        push       = 1'b0;
                        rd_addr_in = front_ff;
                        rd_more_in = 1'b1;
                        rd_vld_in  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHOW: begin
            push     = push_show;
            elem_sel = rd_data;
            last_sel = rd_last_ff;
            // read ahead when the read register is empty or drains now
            rd_en = rd_more_ff && (!rd_vld_ff || push_show);
            if (rd_en) begin
               rd_addr_in = rd_addr_ff + 1'b1;
               rd_more_in = (rd_addr_ff != rear_ff);
               rd_last_in = (rd_addr_ff == rear_ff);
               rd_vld_in  = 1'b1;
            end else if (push_show) begin
               rd_vld_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // element count after the operation; store never wraps so rear >= front
   assign cnt_after = empty_in ? '0 : ({1'b0, rear_in} - {1'b0, front_in} + 1'b1);

   assign push_data = '{status:  status_sel,
                        element: elem_sel,
                        count:   CountWidth'(cnt_after),
                        last:    last_sel};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         front_ff   <= '0;
         rear_ff    <= '0;
         empty_ff   <= 1'b1;
         rd_more_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         rear_ff    <= rear_in;
         empty_ff   <= empty_in;
         rd_more_ff <= rd_more_in;
         rd_vld_ff  <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_last_ff <= rd_last_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_order: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> rear_ff >= front_ff)
      else $error("rear position below front position");

   a_empty_home: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == '0 && rear_ff == '0))
      else $error("empty store with positions away from slot 0");

   a_no_write_in_show: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_IDLE)
      else $error("slot write during display stream");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rd_vld_ff)
      else $error("read data left over after display");

   a_show_ends: assert property (@(posedge clock) disable iff (reset)
      push_show && rd_last_ff |=> state_ff == ST_IDLE)
      else $error("display stream did not end after last element");

endmodule

@@ bench/fixed_array_deque_core_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_array_deque_core_tb
// Self-checking bench for the fixed array deque. A shadow copy of the deque
// predicts every response, and each response transfer is checked field by
// field against the oldest prediction. Directed cases come first: the empty
// store, single elements, both ends hitting their limits, a full display and
// unused commands. Then biased random traffic, a long receiver hold-off that
// backs up the request side, and a final stretch with no idling.
// ----------------------------------------------------------------------------
module fixed_array_deque_core_tb import fad_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 8;
   localparam int HoldCycles = 48;
   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles = 16;

   // Command codes outside the defined set; the block must answer them with status OK and leave the store unchanged
   localparam logic [2:0] CmdUnusedFirst = 3'd5;
   localparam logic [2:0] CmdUnusedMid = 3'd6;
   localparam logic [2:0] CmdUnusedLast = 3'd7;

   localparam logic [31:0] MinValue = 32'h8000_0000;
   localparam logic [31:0] MaxValue = 32'h7FFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow deque
   logic signed [31:0] mirror_slot [Depth];
   logic [2:0]         mirror_front = '0;
   logic [2:0]         mirror_rear = '0;
   logic               mirror_empty = 1'b1;

   rsp_type pending_results [$];
   int      error_count = 0;
   int      quiet_cycles = 0;
   bit      idle_on = 1'b1;
   bit      long_hold_req = 1'b0;

   fixed_array_deque_core #(.DEPTH(Depth)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic logic [3:0] held_count();
      if (mirror_empty) begin
         return 4'd0;
      end
      return {1'b0, mirror_rear} - {1'b0, mirror_front} + 4'd1;
   endfunction

   task automatic mirror_place_first(input logic [31:0] value);
      mirror_front = '0;
      mirror_rear = '0;
      mirror_slot[0] = value;
      mirror_empty = 1'b0;
   endtask

   task automatic mirror_clear();
      mirror_front = '0;
      mirror_rear = '0;
      mirror_empty = 1'b1;
   endtask

   task automatic predict_deque_step(input req_type item);
      rsp_type    res;
      logic [1:0] sts;
      int         idx;
      sts = STS_OK;
      case (item.command)
         CMD_REAR_INS: begin
            if (mirror_empty) begin
               mirror_place_first(item.value);
            end else if (mirror_rear == Depth - 1) begin
               sts = STS_REAR_FULL;
            end else begin
               mirror_rear++;
               mirror_slot[mirror_rear] = item.value;
            end
         end
         CMD_REAR_DEL: begin
            if (mirror_empty) begin
               sts = STS_EMPTY;
            end else if (mirror_front == mirror_rear) begin
               mirror_clear();
            end else begin
               mirror_rear--;
            end
         end
         CMD_FRONT_INS: begin
            if (mirror_empty) begin
               mirror_place_first(item.value);
            end else if (mirror_front == 0) begin
               sts = STS_FRONT_FULL;
            end else begin
               mirror_front--;
               mirror_slot[mirror_front] = item.value;
            end
         end
         CMD_FRONT_DEL: begin
            if (mirror_empty) begin
               sts = STS_EMPTY;
            end else if (mirror_front == mirror_rear) begin
               mirror_clear();
            end else begin
               mirror_front++;
            end
         end
         CMD_DISPLAY: begin
            if (mirror_empty) begin
               sts = STS_EMPTY;
            end else begin
               // one response per held element, front to rear
               for (idx = mirror_front; idx <= mirror_rear; idx++) begin
                  res.status = STS_OK;
                  res.element = mirror_slot[idx];
                  res.count = held_count();
                  res.last = (idx == mirror_rear);
                  pending_results.push_back(res);
               end
               return;
            end
         end
         default: ;
      endcase
      res.status = sts;
      res.element = '0;
      res.count = held_count();
      res.last = 1'b1;
      pending_results.push_back(res);
   endtask

   // ---------------------------------------------------------------------
   // Request side: one transfer, with an optional idle burst in front
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [2:0] cmd, input logic [31:0] value);
      req_type item;
      item.command = cmd;
      item.value = value;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predict_deque_step(item);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return MinValue;
         1: return MaxValue;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Growing traffic moves the front up so front inserts can land,
   // shrinking traffic drains the store toward empty.
   function automatic logic [2:0] pick_command(input bit growing);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         return 3'($urandom_range(CmdUnusedFirst, CmdUnusedLast));
      end
      if (roll < 16) begin
         return CMD_DISPLAY;
      end
      if (growing) begin
         if (roll < 44) return CMD_REAR_INS;
         if (roll < 60) return CMD_FRONT_DEL;
         if (roll < 84) return CMD_FRONT_INS;
         return CMD_REAR_DEL;
      end
      if (roll < 24) return CMD_REAR_INS;
      if (roll < 36) return CMD_FRONT_INS;
      if (roll < 68) return CMD_FRONT_DEL;
      return CMD_REAR_DEL;
   endfunction

   // ---------------------------------------------------------------------
   // Response side pacing: random stall bursts, or a long hold on request
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_error($sformatf("unexpected response status=%0d element=%0d count=%0d",
                                 rsp_data.status, rsp_data.element, rsp_data.count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               flag_error($sformatf("status got %0d want %0d",
                                    rsp_data.status, want.status));
            if (rsp_data.element !== want.element)
               flag_error($sformatf("element got %0d want %0d",
                                    rsp_data.element, want.element));
            if (rsp_data.count !== want.count)
               flag_error($sformatf("count got %0d want %0d",
                                    rsp_data.count, want.count));
            if (rsp_data.last !== want.last)
               flag_error($sformatf("last got %0b want %0b",
                                    rsp_data.last, want.last));
         end
      end
   end

   // Watchdog: too long without any transfer means the block hung
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("fixed_array_deque_core_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Display, both deletes and an unused command, all asked of an empty store
   task automatic test_empty_store();
      send_request(CMD_DISPLAY, pick_value());
      send_request(CMD_REAR_DEL, pick_value());
      send_request(CMD_FRONT_DEL, pick_value());
      send_request(CmdUnusedFirst, pick_value());
   endtask

   // Insert then delete the only element, from each end
   task automatic test_single_element();
      send_request(CMD_REAR_INS, 32'h1234_5678);
      send_request(CMD_REAR_DEL, '0);
      send_request(CMD_FRONT_INS, 32'hCAFE_F00D);
      send_request(CMD_FRONT_DEL, '0);
   endtask

   // Both ends at their limits, extreme values, a full display
   task automatic test_store_limits();
      send_request(CMD_FRONT_INS, MinValue);
      send_request(CMD_FRONT_INS, 32'h0000_0001);
      send_request(CMD_REAR_INS, MaxValue);
      send_request(CMD_REAR_INS, '0);
      send_request(CMD_REAR_INS, '1);
      send_request(CMD_REAR_INS, 32'h5555_5555);
      send_request(CMD_REAR_INS, 32'hAAAA_AAAA);
      send_request(CMD_REAR_INS, 32'h0F0F_F0F0);
      send_request(CMD_REAR_INS, 32'hF0F0_0F0F);
      send_request(CMD_REAR_INS, 32'h0000_0002);
      send_request(CMD_DISPLAY, '0);
      send_request(CMD_FRONT_DEL, '0);
      send_request(CMD_FRONT_INS, 32'h8000_0001);
      send_request(CMD_REAR_DEL, '0);
      send_request(CMD_DISPLAY, '1);
      send_request(CmdUnusedMid, '1);
      send_request(CmdUnusedLast, MinValue);
   endtask

   task automatic test_random_traffic(input int unsigned n);
      bit          growing;
      int unsigned trend_left;
      growing = 1'b0;
      trend_left = 0;
      repeat (n) begin
         if (trend_left == 0) begin
            growing = !growing;
            trend_left = $urandom_range(8, 24);
         end
         trend_left--;
         send_request(pick_command(growing), pick_value());
      end
   endtask

   // Receiver holds off while requests keep coming, so the request side backs up
   task automatic test_backpressure();
      idle_on = 1'b0;
      long_hold_req = 1'b1;
      repeat (16) begin
         send_request(pick_command(1'b1), pick_value());
      end
      idle_on = 1'b1;
   endtask

   // Back-to-back transfers with no idling on either side
   task automatic test_steady_stream(input int unsigned n);
      idle_on = 1'b0;
      test_random_traffic(n);
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_single_element();
      test_store_limits();
      test_random_traffic(290);
      test_backpressure();
      test_steady_stream(40);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("fixed_array_deque_core_tb: done, clean");
      end else begin
         $display("fixed_array_deque_core_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ fixed_array_deque_core.f @@
rtl/core/fad_pkg.sv
rtl/core/fad_ram.sv
rtl/core/fad_rsp_reg.sv
rtl/core/fixed_array_deque_core.sv
bench/fixed_array_deque_core_tb.sv
